// ===== design/bhs_pkg.sv =====
package bhs_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int DIM_W       = 9;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 16;
    localparam int UNIT_W      = FRAC_W + 1;
    localparam int BANK_AW     = (COL_W - 1) + (ROW_W - 1);
    localparam int BANK_DEPTH  = 2 ** BANK_AW;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_POINT = 2'd1,
        FN_BILIN = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_RSVD2  = 2'd2,
        CFG_RSVD3  = 2'd3
    } cfg_idx_t;

    // address stage to bank stage
    typedef struct packed {
        logic                rd;
        logic                zero;
        logic                wr;
        logic [COL_W-1:0]    wr_col;
        logic [ROW_W-1:0]    wr_row;
        logic [SAMPLE_W-1:0] wr_data;
        logic [COL_W-1:0]    x0;
        logic [ROW_W-1:0]    y0;
        logic [FRAC_W-1:0]   tx;
        logic [FRAC_W-1:0]   ty;
        logic [COL_W-1:0]    wm1;
        logic [ROW_W-1:0]    hm1;
    } addr_t;

    // bank stage to blend stage
    typedef struct packed {
        logic              rd;
        logic              zero;
        logic              x0p;
        logic              x1p;
        logic              y0p;
        logic              y1p;
        logic [FRAC_W-1:0] tx;
        logic [FRAC_W-1:0] ty;
    } fetch_t;

endpackage

// ===== design/bilinear_height_sampler_top.sv =====
// Height grid sampler. Requests are taken every cycle (busy stays low);
// a write stores one sample, a point or bilinear read returns height_out
// with height_valid high for one cycle, in request order. The path is
// address/scale multiply, one read of four parity banks (all four
// neighbors at once), two blend multiply stages and a rounding add.
// A write is visible to the very next request.
// The receiver cannot stall: results must be taken when shown.
// cfg_ready is always high; change the grid size only while no read is
// in flight. Unwritten samples read as undefined.
module bilinear_height_sampler_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic signed [15:0]                  col,
    input  logic signed [15:0]                  row,
    input  logic signed [17:0]                  coord_u,
    input  logic signed [17:0]                  coord_v,
    input  logic [15:0]                         sample_in,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bhs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bhs_pkg::DIM_W-1:0]           cfg_data,
    output logic [15:0]                         height_out,
    output logic                                height_valid
);
    import bhs_pkg::*;

    logic [DIM_W-1:0] grid_w_reg, grid_w_next;
    logic [DIM_W-1:0] grid_h_reg, grid_h_next;
    logic             accept;
    addr_t            addr;
    fetch_t           fetch;
    logic [SAMPLE_W-1:0] q [4];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_comb
    begin
        grid_w_next = grid_w_reg;
        grid_h_next = grid_h_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  grid_w_next = (cfg_data > DIM_W'(MAX_WIDTH))
                                          ? DIM_W'(MAX_WIDTH) : cfg_data;
                CFG_HEIGHT: grid_h_next = (cfg_data > DIM_W'(MAX_HEIGHT))
                                          ? DIM_W'(MAX_HEIGHT) : cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg <= '0;
            grid_h_reg <= '0;
        end
        else
        begin
            grid_w_reg <= grid_w_next;
            grid_h_reg <= grid_h_next;
        end
    end

    bhs_addr u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (func_t'(func)),
        .col       (col),
        .row       (row),
        .coord_u   (coord_u),
        .coord_v   (coord_v),
        .sample_in (sample_in),
        .grid_w    (grid_w_reg),
        .grid_h    (grid_h_reg),
        .addr      (addr)
    );

    bhs_banks u_banks (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (addr),
        .fetch (fetch),
        .q     (q)
    );

    bhs_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .fetch  (fetch),
        .q      (q),
        .height (height_out),
        .strobe (height_valid)
    );

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (func == FN_POINT || func == FN_BILIN) |-> ##5 height_valid)
        else $error("read request produced no result");

    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        height_valid |-> $past(start && !busy && (func == FN_POINT || func == FN_BILIN), 5))
        else $error("result without read request");

    a_grid_w_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == CFG_WIDTH |=>
            grid_w_reg <= DIM_W'(MAX_WIDTH))
        else $error("grid width above limit");

    a_zero_map: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (grid_w_reg == '0 || grid_h_reg == '0)
            && (func == FN_POINT || func == FN_BILIN)
            && !(cfg_valid && cfg_ready) |-> ##5 (height_out == '0))
        else $error("invalid map returned nonzero height");
`endif

endmodule

// ===== design/bhs_addr.sv =====
module bhs_addr (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  bhs_pkg::func_t                func,
    input  logic signed [15:0]            col,
    input  logic signed [15:0]            row,
    input  logic signed [17:0]            coord_u,
    input  logic signed [17:0]            coord_v,
    input  logic [bhs_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [bhs_pkg::DIM_W-1:0]     grid_w,
    input  logic [bhs_pkg::DIM_W-1:0]     grid_h,
    output bhs_pkg::addr_t                addr
);
    import bhs_pkg::*;

    localparam logic signed [17:0] ONE_Q = 18'sd65536;

    logic                  rd_reg, rd_next;
    logic                  wr_reg, wr_next;
    logic                  zero_reg, zero_next;
    logic [COL_W-1:0]      wr_col_reg;
    logic [ROW_W-1:0]      wr_row_reg;
    logic [SAMPLE_W-1:0]   wr_data_reg;
    logic [COL_W+FRAC_W-1:0] px_reg, px_next;
    logic [ROW_W+FRAC_W-1:0] py_reg, py_next;
    logic [COL_W-1:0]      wm1_reg, wm1;
    logic [ROW_W-1:0]      hm1_reg, hm1;
    logic [UNIT_W-1:0]     cu, cv;
    logic [UNIT_W+COL_W-1:0] prod_x;
    logic [UNIT_W+ROW_W-1:0] prod_y;
    logic [COL_W-1:0]      colc;
    logic [ROW_W-1:0]      rowc;

    always_comb
    begin
        wm1 = (grid_w == '0) ? '0 : COL_W'(grid_w - 1'b1);
        hm1 = (grid_h == '0) ? '0 : ROW_W'(grid_h - 1'b1);

        if (coord_u < 0)          cu = '0;
        else if (coord_u > ONE_Q) cu = UNIT_W'(ONE_Q);
        else                      cu = coord_u[UNIT_W-1:0];
        if (coord_v < 0)          cv = '0;
        else if (coord_v > ONE_Q) cv = UNIT_W'(ONE_Q);
        else                      cv = coord_v[UNIT_W-1:0];

        prod_x = cu * wm1;
        prod_y = cv * hm1;

        if (col < 0)                              colc = '0;
        else if (col > $signed({8'd0, wm1}))      colc = wm1;
        else                                      colc = col[COL_W-1:0];
        if (row < 0)                              rowc = '0;
        else if (row > $signed({8'd0, hm1}))      rowc = hm1;
        else                                      rowc = row[ROW_W-1:0];

        if (func == FN_BILIN)
        begin
            px_next = prod_x[COL_W+FRAC_W-1:0];
            py_next = prod_y[ROW_W+FRAC_W-1:0];
        end
        else
        begin
            px_next = {colc, {FRAC_W{1'b0}}};
            py_next = {rowc, {FRAC_W{1'b0}}};
        end

        rd_next   = accept && (func == FN_POINT || func == FN_BILIN);
        zero_next = (grid_w == '0) || (grid_h == '0);
        wr_next   = accept && (func == FN_WRITE)
                    && (col[15:COL_W] == '0) && (row[15:ROW_W] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg    <= zero_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        wm1_reg     <= wm1;
        hm1_reg     <= hm1;
        wr_col_reg  <= col[COL_W-1:0];
        wr_row_reg  <= row[ROW_W-1:0];
        wr_data_reg <= sample_in;
    end

    always_comb
    begin
        addr.rd      = rd_reg;
        addr.zero    = zero_reg;
        addr.wr      = wr_reg;
        addr.wr_col  = wr_col_reg;
        addr.wr_row  = wr_row_reg;
        addr.wr_data = wr_data_reg;
        addr.x0      = px_reg[COL_W+FRAC_W-1:FRAC_W];
        addr.y0      = py_reg[ROW_W+FRAC_W-1:FRAC_W];
        addr.tx      = px_reg[FRAC_W-1:0];
        addr.ty      = py_reg[FRAC_W-1:0];
        addr.wm1     = wm1_reg;
        addr.hm1     = hm1_reg;
    end

endmodule

// ===== design/bhs_banks.sv =====
module bhs_banks (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bhs_pkg::addr_t               addr,
    output bhs_pkg::fetch_t              fetch,
    output logic [bhs_pkg::SAMPLE_W-1:0] q [4]
);
    import bhs_pkg::*;

    logic [COL_W-1:0]  x1;
    logic [ROW_W-1:0]  y1;
    logic              rd_reg;
    logic              zero_reg;
    logic              x0p_reg;
    logic              x1p_reg;
    logic              y0p_reg;
    logic              y1p_reg;
    logic [FRAC_W-1:0] tx_reg;
    logic [FRAC_W-1:0] ty_reg;

    // upper neighbor clamps to the last column or row
    assign x1 = (addr.x0 == addr.wm1) ? addr.x0 : addr.x0 + 1'b1;
    assign y1 = (addr.y0 == addr.hm1) ? addr.y0 : addr.y0 + 1'b1;

    // bank b holds x parity b[0], y parity b[1]
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [SAMPLE_W-1:0] mem [BANK_DEPTH];
        logic [COL_W-1:0]    csel;
        logic [ROW_W-1:0]    rsel;
        logic [BANK_AW-1:0]  raddr;
        logic [BANK_AW-1:0]  waddr;

        assign csel  = (addr.x0[0] == b[0]) ? addr.x0 : x1;
        assign rsel  = (addr.y0[0] == b[1]) ? addr.y0 : y1;
        assign raddr = {rsel[ROW_W-1:1], csel[COL_W-1:1]};
        assign waddr = {addr.wr_row[ROW_W-1:1], addr.wr_col[COL_W-1:1]};

        always_ff @(posedge clk)
        begin
            if (addr.wr && addr.wr_col[0] == b[0] && addr.wr_row[0] == b[1])
                mem[waddr] <= addr.wr_data;
            q[b] <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_reg <= 1'b0;
        else
            rd_reg <= addr.rd;
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= addr.zero;
        x0p_reg  <= addr.x0[0];
        x1p_reg  <= x1[0];
        y0p_reg  <= addr.y0[0];
        y1p_reg  <= y1[0];
        tx_reg   <= addr.tx;
        ty_reg   <= addr.ty;
    end

    always_comb
    begin
        fetch.rd   = rd_reg;
        fetch.zero = zero_reg;
        fetch.x0p  = x0p_reg;
        fetch.x1p  = x1p_reg;
        fetch.y0p  = y0p_reg;
        fetch.y1p  = y1p_reg;
        fetch.tx   = tx_reg;
        fetch.ty   = ty_reg;
    end

endmodule

// ===== design/bhs_blend.sv =====
module bhs_blend (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bhs_pkg::fetch_t              fetch,
    input  logic [bhs_pkg::SAMPLE_W-1:0] q [4],
    output logic [bhs_pkg::SAMPLE_W-1:0] height,
    output logic                         strobe
);
    import bhs_pkg::*;

    logic [SAMPLE_W-1:0] h00, h10, h01, h11;
    logic signed [SAMPLE_W+FRAC_W+1:0] r0_next, r1_next;
    logic [31:0]         r0_reg, r1_reg, r0d_reg;
    logic [FRAC_W-1:0]   ty_c_reg;
    logic                c_vld_reg, c_zero_reg;
    logic signed [32:0]  diff;
    logic [31:0]         lo_next, lo_reg;
    logic signed [34:0]  hi_next, hi_reg;
    logic                d_vld_reg, d_zero_reg;
    logic signed [49:0]  sum;
    logic [SAMPLE_W-1:0] height_reg, height_next;
    logic                strobe_reg;

    always_comb
    begin
        h00 = q[{fetch.y0p, fetch.x0p}];
        h10 = q[{fetch.y0p, fetch.x1p}];
        h01 = q[{fetch.y1p, fetch.x0p}];
        h11 = q[{fetch.y1p, fetch.x1p}];
        r0_next = $signed({2'b0, h00, {FRAC_W{1'b0}}})
                  + ($signed({1'b0, h10}) - $signed({1'b0, h00}))
                    * $signed({1'b0, fetch.tx});
        r1_next = $signed({2'b0, h01, {FRAC_W{1'b0}}})
                  + ($signed({1'b0, h11}) - $signed({1'b0, h01}))
                    * $signed({1'b0, fetch.tx});
    end

    always_ff @(posedge clk)
    begin
        r0_reg     <= r0_next[31:0];
        r1_reg     <= r1_next[31:0];
        ty_c_reg   <= fetch.ty;
        c_zero_reg <= fetch.zero;
    end

    // column blend, difference split in two narrow products
    always_comb
    begin
        diff    = $signed({1'b0, r1_reg}) - $signed({1'b0, r0_reg});
        lo_next = diff[15:0] * ty_c_reg;
        hi_next = 35'($signed(diff[32:16]) * $signed({1'b0, ty_c_reg}));
    end

    always_ff @(posedge clk)
    begin
        r0d_reg    <= r0_reg;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        d_zero_reg <= c_zero_reg;
    end

    always_comb
    begin
        sum = $signed({2'b0, r0d_reg, 16'd0}) + (50'(hi_reg) <<< 16)
              + $signed({18'd0, lo_reg}) + $signed(50'd1 << 31);
        height_next = d_zero_reg ? '0 : sum[47:32];
    end

    always_ff @(posedge clk)
    begin
        height_reg <= height_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg  <= 1'b0;
            d_vld_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            c_vld_reg  <= fetch.rd;
            d_vld_reg  <= c_vld_reg;
            strobe_reg <= d_vld_reg;
        end
    end

    assign height = height_reg;
    assign strobe = strobe_reg;

endmodule

// ===== test/height_checker.sv =====
module height_checker
    import bhs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [1:0]           func,
    input  logic signed [15:0]   col,
    input  logic signed [15:0]   row,
    input  logic signed [17:0]   coord_u,
    input  logic signed [17:0]   coord_v,
    input  logic [15:0]          sample_in,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic [15:0]          height_out,
    input  logic                 height_valid,
    output int                   pending,
    output int                   errors,
    output int                   reads_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]      grid_store [MAX_WIDTH*MAX_HEIGHT];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [15:0]      heights_due [$];

    initial
    begin
        width_reg     = '0;
        height_reg    = '0;
        errors        = 0;
        reads_checked = 0;
        pending       = 0;
    end

    function automatic int clampi(int x, int lo, int hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint unsigned stored_at(int x, int y, int w, int h);
        return grid_store[clampi(y, 0, h - 1) * MAX_WIDTH + clampi(x, 0, w - 1)];
    endfunction

    function automatic logic [15:0] predict_height(func_t fn, int c, int r, int u, int v);
        int w;
        int h;
        int unsigned px;
        int unsigned py;
        int x0;
        int y0;
        longint unsigned tx;
        longint unsigned ty;
        longint unsigned r0;
        longint unsigned r1;
        longint unsigned acc;
        w = width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg;
        h = height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg;
        if (w == 0 || h == 0)
            return 16'd0;
        if (fn == FN_POINT)
            return 16'(stored_at(c, r, w, h));
        px = clampi(u, 0, 65536) * (w - 1);
        py = clampi(v, 0, 65536) * (h - 1);
        x0 = px >> 16;
        y0 = py >> 16;
        tx = px & 32'hFFFF;
        ty = py & 32'hFFFF;
        r0 = stored_at(x0, y0, w, h) * (65536 - tx) + stored_at(x0 + 1, y0, w, h) * tx;
        r1 = stored_at(x0, y0 + 1, w, h) * (65536 - tx)
           + stored_at(x0 + 1, y0 + 1, w, h) * tx;
        acc = r0 * (65536 - ty) + r1 * ty;
        return 16'((acc + (64'd1 << 31)) >> 32);
    endfunction

    always @(posedge clk)
    begin
        int c;
        int r;
        logic [15:0] want;
        if (rst_n)
        begin
            if (height_valid)
            begin
                if (heights_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected height %0d, none expected", $time, height_out);
                end
                else
                begin
                    want = heights_due.pop_front();
                    reads_checked++;
                    if (height_out !== want)
                    begin
                        errors++;
                        $display("%0t: height mismatch expected %0d actual %0d",
                                 $time, want, height_out);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == CFG_HEIGHT)
                    height_reg = cfg_data;
            end
            if (start && !busy)
            begin
                c = col;
                r = row;
                case (func_t'(func)) inside
                    FN_WRITE:
                        if (c >= 0 && c < MAX_WIDTH && r >= 0 && r < MAX_HEIGHT)
                            grid_store[r * MAX_WIDTH + c] = sample_in;
                    FN_POINT, FN_BILIN:
                        heights_due.push_back(predict_height(func_t'(func), c, r,
                                                             coord_u, coord_v));
                    default: ;
                endcase
            end
            pending = heights_due.size();
        end
    end

endmodule

// ===== test/tb_bilinear_height_sampler_top.sv =====
module tb_bilinear_height_sampler_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bhs_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           func;
    logic signed [15:0]   col;
    logic signed [15:0]   row;
    logic signed [17:0]   coord_u;
    logic signed [17:0]   coord_v;
    logic [15:0]          sample_in;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic [15:0]          height_out;
    logic                 height_valid;
    int                   pending;
    int                   errors;
    int                   reads_checked;
    int                   idle_pct;
    int                   requests_sent;
    int                   quiet_cycles;

    bilinear_height_sampler_top uut (.*);

    height_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || height_valid || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else if (++quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("[bilinear_height_sampler_top] ERROR");
                $finish;
            end
        end
    end

    task automatic send(func_t fn, int c, int r, int u, int v, int s);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        func      <= fn;
        col       <= 16'(c);
        row       <= 16'(r);
        coord_u   <= 18'(u);
        coord_v   <= 18'(v);
        sample_in <= 16'(s);
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        requests_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_reg(cfg_idx_t idx, int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIM_W'(value);
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_coord();
        case ($urandom_range(3))
            0: return $urandom_range(65536);
            1: return $urandom_range(1) ? 65536 : 0;
            2: return int'(18'($urandom));
            default: return $urandom_range(65536) + 65536 * $urandom_range(1);
        endcase
    endfunction

    function automatic int pick_index();
        if ($urandom_range(3) == 0)
            return int'(16'($urandom));
        return int'($urandom_range(300)) - 20;
    endfunction

    task automatic random_item();
        int k;
        k = $urandom_range(99);
        if (k < 30)
            send(FN_WRITE, pick_index(), pick_index(), int'(18'($urandom)),
                 int'(18'($urandom)), $urandom);
        else if (k < 60)
            send(FN_POINT, pick_index(), pick_index(), int'(18'($urandom)),
                 int'(18'($urandom)), $urandom);
        else if (k < 95)
            send(FN_BILIN, int'(16'($urandom)), int'(16'($urandom)), pick_coord(),
                 pick_coord(), $urandom);
        else
            send(FN_NONE, pick_index(), pick_index(), pick_coord(), pick_coord(), $urandom);
    endtask

    initial
    begin
        int dims [8][2] = '{'{0, 5}, '{511, 1}, '{1, 300}, '{8, 8}, '{256, 0},
                            '{3, 7}, '{256, 1}, '{2, 2}};
        int idle_mix [4] = '{0, 61, 0, 10};
        int p;
        rst_n         = 1'b0;
        start         = 1'b0;
        func          = FN_NONE;
        col           = '0;
        row           = '0;
        coord_u       = '0;
        coord_v       = '0;
        sample_in     = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_WIDTH;
        cfg_data      = '0;
        idle_pct      = 0;
        requests_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // row 0, column 0 and an 8x8 corner are written; every grid shape
        // used below keeps all reads inside them
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
                send(FN_WRITE, x, y, 0, 0, $urandom);
        for (int x = 8; x < MAX_WIDTH; x++)
            send(FN_WRITE, x, 0, 0, 0, $urandom);
        for (int y = 8; y < MAX_HEIGHT; y++)
            send(FN_WRITE, 0, y, 0, 0, $urandom);
        send(FN_WRITE, 0, 0, 0, 0, 16'hFFFF);
        send(FN_WRITE, 255, 0, 0, 0, 0);
        send(FN_WRITE, 1, 0, 0, 0, 0);

        // directed: reads on an invalid map, then edge cases at full width and at width one
        send(FN_POINT, 0, 0, 0, 0, 0);
        send(FN_BILIN, 0, 0, 65536, 65536, 0);
        set_reg(CFG_WIDTH, 256);
        set_reg(CFG_HEIGHT, 1);
        set_reg(CFG_RSVD2, 5);
        set_reg(CFG_RSVD3, 511);
        send(FN_WRITE, -1, 3, 0, 0, 16'h1234);
        send(FN_WRITE, 3, 256, 0, 0, 16'h1234);
        send(FN_WRITE, 32767, -32768, 0, 0, 16'h1234);
        send(FN_POINT, -32768, -32768, 0, 0, 0);
        send(FN_POINT, 32767, 32767, 0, 0, 0);
        send(FN_POINT, 0, 0, 0, 0, 0);
        send(FN_POINT, 255, 255, 0, 0, 0);
        send(FN_BILIN, 0, 0, -131072, -131072, 0);
        send(FN_BILIN, 0, 0, 131071, 131071, 0);
        send(FN_BILIN, 0, 0, 65536, 0, 0);
        send(FN_BILIN, 0, 0, 0, 65536, 0);
        send(FN_BILIN, 0, 0, 32768, 32768, 0);
        send(FN_BILIN, 0, 0, 65535, 1, 0);
        send(FN_BILIN, 0, 0, 257, 65279, 0);
        send(FN_NONE, 5, 5, 100, 100, 0);
        set_reg(CFG_WIDTH, 1);
        set_reg(CFG_HEIGHT, 300);
        send(FN_POINT, 32767, 32767, 0, 0, 0);
        send(FN_BILIN, 0, 0, 65536, 65536, 0);
        send(FN_BILIN, 0, 0, 32768, 257, 0);
        send(FN_WRITE, 0, 0, 0, 0, 16'hFFFF);
        send(FN_POINT, 0, 0, 0, 0, 0);
        send(FN_BILIN, 0, 0, 0, 0, 0);

        p = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            set_reg(CFG_WIDTH, dims[ph][0]);
            set_reg(CFG_HEIGHT, dims[ph][1]);
            for (int i = 0; i < 75; i++)
            begin
                idle_pct = idle_mix[(p / 25) % 4];
                p++;
                if (i == 37 && ph % 3 == 0)
                    drain();
                random_item();
            end
        end
        idle_pct = 0;
        drain();
        repeat (10) @(posedge clk);

        $display("%0d requests sent, %0d heights checked over %0d grid sizes",
                 requests_sent, reads_checked, 8);
        if (errors == 0 && pending == 0)
            $display("[bilinear_height_sampler_top] OK");
        else
            $display("[bilinear_height_sampler_top] ERROR");
        $finish;
    end

endmodule
